// ===== hdl/swdd_pkg.sv =====
// Package for the sync word deframer / derandomizer.
// Holds register codes, config and byte-info structs, and the PN sequence table.
// No dependencies.
`default_nettype none

package swdd_pkg;

	localparam int PN_LEN             = 255;
	localparam int MAX_INTERLEAVE_DEF = 8;
	localparam int CFG_IDX_W          = 2;
	localparam int CFG_DATA_W         = 32;

	localparam logic [31:0] SYNC_WORD_RST = 32'h1ACFFC1D;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERAND_EN  = 2'd3;

	typedef struct packed {
		logic [31:0] sync_word;
		logic [5:0]  max_bit_errors;
		logic        derand_en;
	} swdd_cfg_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       last;
	} swdd_byte_t;

	// CCSDS pseudo-random sequence; last entry is padding, never addressed
	localparam logic [7:0] PN_TABLE [0:255] = '{
		8'd255, 8'd72, 8'd14, 8'd192, 8'd154, 8'd13, 8'd112, 8'd188,
		8'd142, 8'd44, 8'd147, 8'd173, 8'd167, 8'd183, 8'd70, 8'd206,
		8'd90, 8'd151, 8'd125, 8'd204, 8'd50, 8'd162, 8'd191, 8'd62,
		8'd10, 8'd16, 8'd241, 8'd136, 8'd148, 8'd205, 8'd234, 8'd177,
		8'd254, 8'd144, 8'd29, 8'd129, 8'd52, 8'd26, 8'd225, 8'd121,
		8'd28, 8'd89, 8'd39, 8'd91, 8'd79, 8'd110, 8'd141, 8'd156,
		8'd181, 8'd46, 8'd251, 8'd152, 8'd101, 8'd69, 8'd126, 8'd124,
		8'd20, 8'd33, 8'd227, 8'd17, 8'd41, 8'd155, 8'd213, 8'd99,
		8'd253, 8'd32, 8'd59, 8'd2, 8'd104, 8'd53, 8'd194, 8'd242,
		8'd56, 8'd178, 8'd78, 8'd182, 8'd158, 8'd221, 8'd27, 8'd57,
		8'd106, 8'd93, 8'd247, 8'd48, 8'd202, 8'd138, 8'd252, 8'd248,
		8'd40, 8'd67, 8'd198, 8'd34, 8'd83, 8'd55, 8'd170, 8'd199,
		8'd250, 8'd64, 8'd118, 8'd4, 8'd208, 8'd107, 8'd133, 8'd228,
		8'd113, 8'd100, 8'd157, 8'd109, 8'd61, 8'd186, 8'd54, 8'd114,
		8'd212, 8'd187, 8'd238, 8'd97, 8'd149, 8'd21, 8'd249, 8'd240,
		8'd80, 8'd135, 8'd140, 8'd68, 8'd166, 8'd111, 8'd85, 8'd143,
		8'd244, 8'd128, 8'd236, 8'd9, 8'd160, 8'd215, 8'd11, 8'd200,
		8'd226, 8'd201, 8'd58, 8'd218, 8'd123, 8'd116, 8'd108, 8'd229,
		8'd169, 8'd119, 8'd220, 8'd195, 8'd42, 8'd43, 8'd243, 8'd224,
		8'd161, 8'd15, 8'd24, 8'd137, 8'd76, 8'd222, 8'd171, 8'd31,
		8'd233, 8'd1, 8'd216, 8'd19, 8'd65, 8'd174, 8'd23, 8'd145,
		8'd197, 8'd146, 8'd117, 8'd180, 8'd246, 8'd232, 8'd217, 8'd203,
		8'd82, 8'd239, 8'd185, 8'd134, 8'd84, 8'd87, 8'd231, 8'd193,
		8'd66, 8'd30, 8'd49, 8'd18, 8'd153, 8'd189, 8'd86, 8'd63,
		8'd210, 8'd3, 8'd176, 8'd38, 8'd131, 8'd92, 8'd47, 8'd35,
		8'd139, 8'd36, 8'd235, 8'd105, 8'd237, 8'd209, 8'd179, 8'd150,
		8'd165, 8'd223, 8'd115, 8'd12, 8'd168, 8'd175, 8'd207, 8'd130,
		8'd132, 8'd60, 8'd98, 8'd37, 8'd51, 8'd122, 8'd172, 8'd127,
		8'd164, 8'd7, 8'd96, 8'd77, 8'd6, 8'd184, 8'd94, 8'd71,
		8'd22, 8'd73, 8'd214, 8'd211, 8'd219, 8'd163, 8'd103, 8'd45,
		8'd75, 8'd190, 8'd230, 8'd25, 8'd81, 8'd95, 8'd159, 8'd5,
		8'd8, 8'd120, 8'd196, 8'd74, 8'd102, 8'd245, 8'd88, 8'd0
	};

endpackage

`default_nettype wire

// ===== hdl/swdd_cfg_regs.sv =====
// Configuration register file for the deframer.
// Clamps interleave depth and keeps the frame length in bytes. Uses swdd_pkg.
`default_nettype none

module swdd_cfg_regs import swdd_pkg::*; #(
	parameter int MAX_INTERLEAVE = MAX_INTERLEAVE_DEF,
	parameter int LEN_W          = $clog2(PN_LEN * MAX_INTERLEAVE + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output swdd_cfg_t                  cfg,
	output logic [LEN_W-1:0]           frame_len
);

	swdd_cfg_t        cfg_q;
	logic [LEN_W-1:0] frame_len_q;
	logic [3:0]       depth;
	logic [LEN_W-1:0] frame_len_d;

	assign cfg_ready = 1'b1;

	always_comb begin
		depth = cfg_data[3:0];
		if (depth == 4'd0) begin
			depth = 4'd1;
		end else if (depth > 4'(MAX_INTERLEAVE)) begin
			depth = 4'(MAX_INTERLEAVE);
		end
		frame_len_d = LEN_W'(depth) * LEN_W'(PN_LEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word      <= SYNC_WORD_RST;
			cfg_q.max_bit_errors <= 6'd0;
			cfg_q.derand_en      <= 1'b0;
			frame_len_q          <= LEN_W'(PN_LEN);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SYNC_WORD:  cfg_q.sync_word      <= cfg_data[31:0];
				REG_MAX_ERRORS: cfg_q.max_bit_errors <= cfg_data[5:0];
				REG_INTERLEAVE: frame_len_q          <= frame_len_d;
				REG_DERAND_EN:  cfg_q.derand_en      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg       = cfg_q;
	assign frame_len = frame_len_q;

endmodule

`default_nettype wire

// ===== hdl/swdd_sync_match.sv =====
// Sync marker comparator: popcount of (window ^ sync word) against the tolerance.
// Adder tree over the 32-bit mismatch vector. Uses swdd_pkg.
`default_nettype none

module swdd_sync_match import swdd_pkg::*; (
	input  wire logic [31:0] window,
	input  wire swdd_cfg_t   cfg,
	output logic             match
);

	logic [31:0]    diff;
	logic [1:0]     sum2  [16];
	logic [2:0]     sum4  [8];
	logic [3:0]     sum8  [4];
	logic [4:0]     sum16 [2];
	logic [5:0]     mismatch_cnt;

	always_comb begin
		diff = window ^ cfg.sync_word;
		for (int i = 0; i < 16; i++) begin
			sum2[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			sum4[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			sum8[i] = {1'b0, sum4[2*i]} + {1'b0, sum4[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			sum16[i] = {1'b0, sum8[2*i]} + {1'b0, sum8[2*i+1]};
		end
		mismatch_cnt = {1'b0, sum16[0]} + {1'b0, sum16[1]};
		match        = (mismatch_cnt <= cfg.max_bit_errors);
	end

endmodule

`default_nettype wire

// ===== hdl/swdd_byte_asm.sv =====
// Frame state and byte assembly: search/data mode, bit and byte counters,
// PN derandomizing. Uses swdd_pkg and swdd_sync_match.
`default_nettype none

module swdd_byte_asm import swdd_pkg::*; #(
	parameter int MAX_INTERLEAVE = MAX_INTERLEAVE_DEF,
	parameter int LEN_W          = $clog2(PN_LEN * MAX_INTERLEAVE + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             bit_in,
	input  wire swdd_cfg_t        cfg,
	input  wire logic [LEN_W-1:0] frame_len,
	output swdd_byte_t            byte_info
);

	logic             in_frame_q;
	logic [31:0]      shift_q;
	logic [2:0]       bit_cnt_q;
	logic [LEN_W-1:0] byte_cnt_q;
	logic [7:0]       pn_idx_q;

	logic [31:0]      shift_nx;
	logic [LEN_W-1:0] byte_cnt_inc;
	logic             match;

	assign shift_nx     = {shift_q[30:0], bit_in};
	assign byte_cnt_inc = byte_cnt_q + LEN_W'(1);

	swdd_sync_match u_match (
		.window (shift_nx),
		.cfg    (cfg),
		.match  (match)
	);

	always_comb begin
		byte_info.emit = in_frame_q && (bit_cnt_q == 3'd7);
		byte_info.data = shift_nx[7:0] ^ (cfg.derand_en ? PN_TABLE[pn_idx_q] : 8'd0);
		byte_info.last = (byte_cnt_inc >= frame_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			shift_q    <= 32'd0;
			bit_cnt_q  <= 3'd0;
			byte_cnt_q <= '0;
			pn_idx_q   <= 8'd0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (match) begin
					in_frame_q <= 1'b1;
					bit_cnt_q  <= 3'd0;
					shift_q    <= 32'd0;
				end else begin
					shift_q <= shift_nx;
				end
			end else if (!byte_info.emit) begin
				bit_cnt_q <= bit_cnt_q + 3'd1;
				shift_q   <= shift_nx;
			end else begin
				shift_q   <= 32'd0;
				bit_cnt_q <= 3'd0;
				if (byte_info.last) begin
					in_frame_q <= 1'b0;
					byte_cnt_q <= '0;
					pn_idx_q   <= 8'd0;
				end else begin
					byte_cnt_q <= byte_cnt_inc;
					pn_idx_q   <= (pn_idx_q == 8'(PN_LEN - 1)) ? 8'd0 : pn_idx_q + 8'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sync_word_deframer_derandomizer_unit.sv =====
// Top level of the sync word deframer / derandomizer.
// Uses swdd_pkg, swdd_cfg_regs and swdd_byte_asm.
//
// Takes one received bit per clock, searches for the 32-bit sync marker
// (within max_bit_errors mismatches), then packs the following bits MSB first
// into bytes, optionally XORs each with the CCSDS PN sequence, and flags the
// last byte of each 255 * interleave_depth byte frame before searching again.
// Throughput is one bit per clock while in_stall is low; an accepted bit is held
// in an input register until it is processed, and a completed byte is loaded into
// the output register as its eighth bit is processed. The input stalls only when
// a byte completes while the previous byte is still held by a stalled output.
// Configuration writes are always accepted and take effect on the next bit.
`default_nettype none

module sync_word_deframer_derandomizer_unit import swdd_pkg::*; #(
	parameter int MAX_INTERLEAVE = MAX_INTERLEAVE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  rx_bit,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 data_byte,
	output logic                       frame_end
);

	localparam int LEN_W = $clog2(PN_LEN * MAX_INTERLEAVE + 1);

	swdd_cfg_t        cfg;
	logic [LEN_W-1:0] frame_len;
	swdd_byte_t       byte_info;

	logic       valid_s1;
	logic       rx_bit_s1;
	logic       out_valid_q;
	logic [7:0] data_byte_s2;
	logic       frame_end_s2;
	logic       advance;
	logic       out_take;

	swdd_cfg_regs #(
		.MAX_INTERLEAVE (MAX_INTERLEAVE),
		.LEN_W          (LEN_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.frame_len (frame_len)
	);

	swdd_byte_asm #(
		.MAX_INTERLEAVE (MAX_INTERLEAVE),
		.LEN_W          (LEN_W)
	) u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.bit_in    (rx_bit_s1),
		.cfg       (cfg),
		.frame_len (frame_len),
		.byte_info (byte_info)
	);

	assign out_take = out_valid_q && !out_stall;
	assign advance  = valid_s1 && (!byte_info.emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_bit_s1 <= rx_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && byte_info.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && byte_info.emit) begin
			data_byte_s2 <= byte_info.data;
			frame_end_s2 <= byte_info.last;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_byte_s2;
	assign frame_end = frame_end_s2;

	a_byte_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_info.emit) |=> (out_valid_q && frame_end_s2 == $past(byte_info.last)))
		else $error("completed byte not loaded into output register");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && byte_info.emit && out_valid_q && out_stall))
		else $error("input stalled without a blocked output");

	a_output_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && !(advance && byte_info.emit)) |=> !out_valid_q)
		else $error("taken byte still shown as valid");

endmodule

`default_nettype wire

// ===== bench/sync_word_deframer_derandomizer_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench for sync_word_deframer_derandomizer_unit: directed and random bit streams
// against an in-bench deframer predictor, with random idling and a long output hold-off.
// Depends on swdd_pkg and the RTL of the block.
module sync_word_deframer_derandomizer_unit_test import swdd_pkg::*;;

	localparam int DEPTH_MAX    = 8;
	localparam int FRAME_BLOCK  = 255;
	localparam int GAP_MAX      = 13;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BITS  = 1300;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int PRINT_LIMIT  = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic                  rx_bit     = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [7:0]            data_byte;
	logic                  frame_end;

	// deframer state and settings as the bench sees them
	logic [31:0] sync_pattern    = 32'h1ACF_FC1D;
	logic [5:0]  bit_tolerance   = 6'd0;
	logic [3:0]  depth_setting   = 4'd1;
	logic        derand_on       = 1'b0;
	logic        locked          = 1'b0;
	logic [31:0] shift_reg       = '0;
	logic [2:0]  bit_count       = '0;
	logic [10:0] byte_count      = '0;

	logic [7:0]  pn_bytes [0:FRAME_BLOCK-1];
	frame_byte_t pending_bytes [$];

	int   errors        = 0;
	int   cycles        = 0;
	int   bits_sent     = 0;
	int   send_gap_max  = GAP_MAX;
	int   recv_gap_max  = GAP_MAX;
	int   recv_wait     = 0;
	bit   hold_active   = 1'b0;
	event hold_request;

	sync_word_deframer_derandomizer_unit #(.MAX_INTERLEAVE(DEPTH_MAX)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_bit    (rx_bit),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_byte (data_byte),
		.frame_end (frame_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// PN sequence from x^8+x^7+x^5+x^3+1, all-ones seed
	initial begin : build_pn_table
		bit pn_bits [0:8*FRAME_BLOCK-1];
		for (int n = 0; n < 8*FRAME_BLOCK; n++) begin
			if (n < 8)
				pn_bits[n] = 1'b1;
			else
				pn_bits[n] = pn_bits[n-1] ^ pn_bits[n-3] ^ pn_bits[n-5] ^ pn_bits[n-8];
		end
		for (int i = 0; i < FRAME_BLOCK; i++)
			for (int j = 0; j < 8; j++)
				pn_bytes[i][7-j] = pn_bits[8*i+j];
	end

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		case (idx)
			REG_SYNC_WORD:  sync_pattern  = val;
			REG_MAX_ERRORS: bit_tolerance = val[5:0];
			REG_INTERLEAVE: depth_setting = val[3:0];
			REG_DERAND_EN:  derand_on     = val[0];
			default: ;
		endcase
	endfunction

	function automatic void deframe_bit(input logic b);
		frame_byte_t got;
		int          depth;
		shift_reg = {shift_reg[30:0], b};
		if (!locked) begin
			if ($countones(shift_reg ^ sync_pattern) <= bit_tolerance) begin
				locked    = 1'b1;
				bit_count = '0;
				shift_reg = '0;
			end
			return;
		end
		if (bit_count < 3'd7) begin
			bit_count++;
			return;
		end
		got.data = shift_reg[7:0];
		if (derand_on)
			got.data ^= pn_bytes[byte_count % FRAME_BLOCK];
		byte_count = byte_count + 11'd1;
		shift_reg  = '0;
		bit_count  = '0;
		depth = int'(depth_setting);
		if (depth == 0)
			depth = 1;
		if (depth > DEPTH_MAX)
			depth = DEPTH_MAX;
		got.last = (byte_count >= FRAME_BLOCK * depth);
		if (got.last) begin
			locked     = 1'b0;
			byte_count = '0;
		end
		pending_bytes.push_back(got);
	endfunction

	function automatic logic [31:0] error_pattern(input int k);
		logic [31:0] m;
		m = '0;
		while ($countones(m) < k)
			m[$urandom_range(31)] = 1'b1;
		return m;
	endfunction

	task automatic report_mismatch(input string what);
		if (errors < PRINT_LIMIT)
			$display("MISMATCH @%0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic send_bit(input logic b);
		int gap;
		gap = $urandom_range(send_gap_max);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
			rx_bit   = 1'($urandom);
		end
		@(negedge clk);
		in_valid = 1'b1;
		rx_bit   = b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		deframe_bit(b);
		bits_sent++;
	endtask

	task automatic send_byte(input logic [7:0] v);
		for (int i = 7; i >= 0; i--)
			send_bit(v[i]);
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 31; i >= 0; i--)
			send_bit(w[i]);
	endtask

	task automatic send_noise(input int n);
		repeat (n)
			send_bit(1'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic run_out_frame();
		while (locked)
			send_bit(1'($urandom));
	endtask

	// receiver: per-result stall plus the long hold-off
	always @(negedge clk) begin
		out_stall = hold_active || (recv_wait > 0);
		if (recv_wait > 0)
			recv_wait--;
	end

	always begin
		@(hold_request);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		hold_active = 1'b0;
	end

	always @(posedge clk) begin : check_output
		frame_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h frame_end %0b",
					data_byte, frame_end));
			end else begin
				want = pending_bytes.pop_front();
				if (data_byte !== want.data)
					report_mismatch($sformatf("data_byte %02h, expected %02h",
						data_byte, want.data));
				if (frame_end !== want.last)
					report_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h",
						frame_end, want.last, want.data));
			end
			recv_wait = $urandom_range(recv_gap_max);
		end
	end

	task automatic test_reset_defaults();
		send_gap_max = GAP_MAX;
		recv_gap_max = GAP_MAX;
		send_noise(5);
		send_word(32'h1ACF_FC1D);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h5A);
		wait_drained();
	endtask

	task automatic test_derandomize();
		write_reg(REG_DERAND_EN, 32'd1);
		send_gap_max = 3;
		run_out_frame();
		send_gap_max = GAP_MAX;
		send_noise(12);
		wait_drained();
	endtask

	task automatic test_tolerance();
		logic [31:0] pat;
		pat = $urandom;
		write_reg(REG_SYNC_WORD, pat);
		write_reg(REG_MAX_ERRORS, 32'd3);
		send_word(pat ^ error_pattern(4));
		send_word(pat ^ error_pattern(3));
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		wait_drained();
		// tolerance of 32 locks on the first bit of the search
		write_reg(REG_MAX_ERRORS, 32'd32);
		write_reg(REG_INTERLEAVE, 32'd0);
		send_gap_max = 2;
		run_out_frame();
		send_gap_max = GAP_MAX;
		send_bit(1'($urandom));
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		wait_drained();
		write_reg(REG_MAX_ERRORS, 32'd0);
		write_reg(REG_SYNC_WORD, 32'hFFFF_FFFF);
		send_gap_max = 2;
		run_out_frame();
		send_gap_max = GAP_MAX;
		send_noise(3);
		send_word(32'hFFFF_FFFF);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		wait_drained();
	endtask

	task automatic test_depth_limits();
		write_reg(REG_SYNC_WORD, 32'h0000_0000);
		write_reg(REG_INTERLEAVE, 32'd15);
		send_gap_max = 1;
		recv_gap_max = GAP_MAX;
		run_out_frame();
		wait_drained();
	endtask

	task automatic test_depth_lowered();
		write_reg(REG_INTERLEAVE, 32'd8);
		send_gap_max = 1;
		send_noise(4);
		send_word(32'h0000_0000);
		repeat (300)
			send_byte(8'($urandom));
		wait_drained();
		write_reg(REG_INTERLEAVE, 32'd1);
		send_gap_max = GAP_MAX;
		send_byte(8'($urandom));
		send_noise(10);
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_reg(REG_INTERLEAVE, 32'd2);
		write_reg(REG_DERAND_EN, 32'd0);
		send_gap_max = 0;
		recv_gap_max = 0;
		send_word(32'h0000_0000);
		-> hold_request;
		repeat (64)
			send_byte(8'($urandom));
		wait_drained();
	endtask

	task automatic test_random();
		int fills;
		int skipped;
		int start_bits;
		int mark;
		int k;
		fills      = 0;
		skipped    = 0;
		start_bits = bits_sent;
		while (bits_sent - start_bits - skipped < RANDOM_BITS) begin
			wait_drained();
			send_gap_max = ($urandom_range(2) == 0) ? 0 : GAP_MAX;
			recv_gap_max = ($urandom_range(2) == 0) ? 0 : GAP_MAX;
			if (locked && fills < 3 && $urandom_range(3) == 0) begin
				// shorten the open frame so the search is reached again
				write_reg(REG_INTERLEAVE, {$urandom} & 32'hFFFF_FFF0 | $urandom_range(1));
				mark = bits_sent;
				run_out_frame();
				skipped += bits_sent - mark;
				fills++;
				wait_drained();
			end
			if ($urandom_range(1))
				write_reg(REG_SYNC_WORD, $urandom);
			if ($urandom_range(1)) begin
				k = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(4);
				write_reg(REG_MAX_ERRORS, {$urandom} & 32'hFFFF_FFC0 | k);
			end
			if ($urandom_range(1))
				write_reg(REG_INTERLEAVE, {$urandom} & 32'hFFFF_FFF0 | $urandom_range(15));
			if ($urandom_range(1))
				write_reg(REG_DERAND_EN, $urandom);
			if (!locked && $urandom_range(4) != 0) begin
				send_noise($urandom_range(40));
				k = (bit_tolerance > 31) ? 32 : bit_tolerance + 1;
				send_word(sync_pattern ^ error_pattern($urandom_range(k)));
				send_noise($urandom_range(200, 16));
			end else begin
				send_noise($urandom_range(100, 20));
			end
		end
		wait_drained();
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("sync_word_deframer_derandomizer_unit_test: errors");
		$finish;
	end

	initial begin
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_derandomize();
		test_tolerance();
		test_depth_limits();
		test_depth_lowered();
		test_backpressure();
		test_random();
		wait_drained();
		if (errors == 0) begin
			$display("sync_word_deframer_derandomizer_unit_test: clean");
		end else begin
			$display("sync_word_deframer_derandomizer_unit_test: errors");
		end
		$finish;
	end

endmodule
